// ----- hdl/rbsm_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbsm_pkg
// Shared types, codes and helper functions of the ROM bank switch mapper.
// ----------------------------------------------------------------------------
package rbsm_pkg;

	// Field widths
	localparam int OP_W       = 2;
	localparam int ADDR_W     = 16;
	localparam int VALUE_W    = 8;
	localparam int OFFSET_W   = 21;
	localparam int PAGES_W    = 4;
	localparam int VARIANT_W  = 3;
	localparam int COUNT_W    = 9;
	localparam int BANK_W     = 8;
	localparam int NUM_BANKS  = 8;
	localparam int SEL_W      = 3;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 9;
	localparam int S_DATA_W   = 24;
	localparam int M_DATA_W   = 32;

	// Default for the byte offset width kept in mapped_offset
	localparam int OFFSET_BITS_DEF = 21;

	// Operation codes carried in tuser
	typedef enum logic [OP_W-1:0] {
		OP_WRITE = 2'd0,
		OP_PRG   = 2'd1,
		OP_CHR   = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	// Board variant codes (5 to 7 act as base)
	localparam logic [VARIANT_W-1:0] VAR_BASE   = 3'd0;
	localparam logic [VARIANT_W-1:0] VAR_CHR2K  = 3'd1;
	localparam logic [VARIANT_W-1:0] VAR_CHRHI  = 3'd2;
	localparam logic [VARIANT_W-1:0] VAR_NTCTL  = 3'd3;
	localparam logic [VARIANT_W-1:0] VAR_SINGLE = 3'd4;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_VARIANT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PRG_CNT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CHR_CNT = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_MIRROR  = 2'd3;

	// Quadrant page patterns
	localparam logic [PAGES_W-1:0] PAGES_HORZ   = 4'hC;
	localparam logic [PAGES_W-1:0] PAGES_VERT   = 4'hA;
	localparam logic [PAGES_W-1:0] PAGES_ALL_1  = 4'hF;
	localparam logic [PAGES_W-1:0] PAGES_ALL_0  = 4'h0;

	// Fixed program banks of windows 2 and 3
	localparam logic [BANK_W-1:0] PRG_BANK_2ND_LAST = 8'hFE;
	localparam logic [BANK_W-1:0] PRG_BANK_LAST     = 8'hFF;

	// Mapper state seen by the translate logic
	typedef struct packed {
		logic [VARIANT_W-1:0]             variant;
		logic [BANK_W-1:0]                prg_mask;
		logic [BANK_W-1:0]                chr_mask;
		logic [NUM_BANKS-1:0][BANK_W-1:0] banks;
	} map_state_t;

	// Item being retired, as seen by the bank file
	typedef struct packed {
		logic               wr_en;
		logic               odd;
		logic [VALUE_W-1:0] value;
	} bus_write_t;

	// Bank count to wrap mask: zero acts as one, above 256 acts as 256
	function automatic logic [BANK_W-1:0] count_mask(input logic [COUNT_W-1:0] count);
		logic [COUNT_W-1:0] m;
		begin
			m = count - 9'd1;
			if (count == '0) begin
				count_mask = '0;
			end else if (count > 9'd256) begin
				count_mask = '1;
			end else begin
				count_mask = m[BANK_W-1:0];
			end
		end
	endfunction

	// Bank register value as read for translation
	function automatic logic [BANK_W-1:0] eff_reg(
		input logic [VARIANT_W-1:0] variant,
		input logic [SEL_W-1:0]     idx,
		input logic [BANK_W-1:0]    raw
	);
		logic [BANK_W-1:0] r;
		begin
			r = raw;
			if (variant == VAR_CHRHI || variant == VAR_SINGLE) begin
				if (idx <= 3'd1) begin
					r = raw & 8'h3F;
				end else if (idx <= 3'd5) begin
					r = raw | 8'h40;
				end
			end
			eff_reg = r;
		end
	endfunction

endpackage

// ----- hdl/rom_bank_switch_mapper_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rom_bank_switch_mapper_unit
// Cartridge bank switching mapper: register writes and address translation.
// ----------------------------------------------------------------------------
// Input stream s_*: one word per bus access. s_tuser holds the operation
// (write, program translate, character translate); s_tdata holds the address
// and the written byte. Output stream m_*: one word per input word with the
// ROM byte offset (zero for writes) and the four quadrant page bits as they
// stand after that access.
// Configuration channel cfg_*: always ready, index selects variant, program
// bank count, character bank count or initial mirroring. Write it only while
// no word is in flight.
// Pipeline: one input register and one result register with the translate
// logic between; a word passes the input register, then the result register,
// to m_tvalid. Throughput is one word per cycle unless the receiver stalls;
// each word updates the bank registers as it enters the result register, so
// the next word sees the new state. On a stall the result register holds;
// the input register keeps accepting until it is full, then s_tready drops.
// Reset restores the power-on bank registers, horizontal mirroring, 16
// program banks and 64 character banks, and empties both registers.
// ----------------------------------------------------------------------------
module rom_bank_switch_mapper_unit
	import rbsm_pkg::*;
#(
	parameter int OFFSET_BITS = OFFSET_BITS_DEF
)
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [S_DATA_W-1:0]   s_tdata,   // [15:0] address, [23:16] bus_value
	input  logic [OP_W-1:0]       s_tuser,   // [1:0] operation
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [M_DATA_W-1:0]   m_tdata,   // [20:0] mapped_offset, [24:21] nametable_select
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	logic                valid_s1;
	op_t                 op_s1;
	logic [ADDR_W-1:0]   addr_s1;
	logic [VALUE_W-1:0]  value_s1;
	logic                valid_q;
	logic [OFFSET_W-1:0] offset_q;
	logic [PAGES_W-1:0]  pages_q;
	logic                advance;
	logic                accept;
	map_state_t          state;
	bus_write_t          bus_wr;
	logic [PAGES_W-1:0]  pages_next;
	logic [OFFSET_W-1:0] offset;

	assign advance   = !valid_q || m_tready;
	assign s_tready  = !valid_s1 || advance;
	assign accept    = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;

	// Retiring word drives the bank file update
	assign bus_wr.wr_en = valid_s1 && advance && op_s1 == OP_WRITE && addr_s1[ADDR_W-1];
	assign bus_wr.odd   = addr_s1[0];
	assign bus_wr.value = value_s1;

	rbsm_bank_file u_bank_file (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr     (cfg_valid),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.bus_wr     (bus_wr),
		.state      (state),
		.pages_next (pages_next)
	);

	rbsm_xlate #(
		.OFFSET_BITS (OFFSET_BITS)
	) u_xlate (
		.op      (op_s1),
		.address (addr_s1),
		.state   (state),
		.offset  (offset)
	);

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1    <= op_t'(s_tuser);
			addr_s1  <= s_tdata[ADDR_W-1:0];
			value_s1 <= s_tdata[ADDR_W+VALUE_W-1:ADDR_W];
		end
	end

	// Result register: advance when empty or taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			offset_q <= offset;
			pages_q  <= pages_next;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = {{(M_DATA_W-OFFSET_W-PAGES_W){1'b0}}, pages_q, offset_q};

endmodule

// ----- hdl/rbsm_bank_file.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbsm_bank_file
// Configuration registers, register select, bank registers and quadrant pages.
// ----------------------------------------------------------------------------
module rbsm_bank_file
	import rbsm_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  bus_write_t            bus_wr,
	output map_state_t            state,
	output logic [PAGES_W-1:0]    pages_next
);

	logic [VARIANT_W-1:0]             variant_q;
	logic [BANK_W-1:0]                prg_mask_q;
	logic [BANK_W-1:0]                chr_mask_q;
	logic [SEL_W-1:0]                 sel_q;
	logic [NUM_BANKS-1:0][BANK_W-1:0] banks_q;
	logic [PAGES_W-1:0]               pages_q;
	logic [BANK_W-1:0]                wr_value;
	logic                             nt_a;
	logic                             nt_b;

	// Registers 0 and 1 drop bit 0 on load
	assign wr_value = (sel_q <= 3'd1) ? (bus_wr.value & 8'hFE) : bus_wr.value;

	// Bit 5 of registers 0 and 1 after this write
	assign nt_a = (bus_wr.odd && sel_q == 3'd0) ? wr_value[5] : banks_q[0][5];
	assign nt_b = (bus_wr.odd && sel_q == 3'd1) ? wr_value[5] : banks_q[1][5];

	// Quadrant pages after the retiring item
	always_comb begin
		pages_next = pages_q;
		if (bus_wr.wr_en) begin
			if (variant_q == VAR_SINGLE) begin
				pages_next = bus_wr.value[6] ? PAGES_ALL_1 : PAGES_ALL_0;
			end
			if (bus_wr.odd && variant_q == VAR_NTCTL) begin
				pages_next = {nt_b, nt_b, nt_a, nt_a};
			end
		end
	end

	// Configuration and mapper state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			variant_q  <= VAR_BASE;
			prg_mask_q <= 8'd15;
			chr_mask_q <= 8'd63;
			sel_q      <= '0;
			banks_q    <= {8'd1, 8'd0, 8'd7, 8'd6, 8'd5, 8'd4, 8'd2, 8'd0};
			pages_q    <= PAGES_HORZ;
		end else begin
			if (cfg_wr) begin
				case (cfg_index)
					CFG_VARIANT: variant_q  <= cfg_data[VARIANT_W-1:0];
					CFG_PRG_CNT: prg_mask_q <= count_mask(cfg_data);
					CFG_CHR_CNT: chr_mask_q <= count_mask(cfg_data);
					CFG_MIRROR: begin
						pages_q  <= cfg_data[0] ? PAGES_VERT : PAGES_HORZ;
					end
					default: ;
				endcase
			end else begin
				pages_q <= pages_next;
			end
			if (bus_wr.wr_en) begin
				if (bus_wr.odd) begin
					banks_q[sel_q] <= wr_value;
				end else begin
					sel_q <= bus_wr.value[SEL_W-1:0];
				end
			end
		end
	end

	// Expose the mapper state to the translate logic
	assign state.variant  = variant_q;
	assign state.prg_mask = prg_mask_q;
	assign state.chr_mask = chr_mask_q;
	assign state.banks    = banks_q;

endmodule

// ----- hdl/rbsm_xlate.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbsm_xlate
// Translates a program or character address into a ROM byte offset.
// ----------------------------------------------------------------------------
module rbsm_xlate
	import rbsm_pkg::*;
#(
	parameter int OFFSET_BITS = OFFSET_BITS_DEF
)
(
	input  op_t                 op,
	input  logic [ADDR_W-1:0]   address,
	input  map_state_t          state,
	output logic [OFFSET_W-1:0] offset
);

	localparam int KEEP_BITS = (OFFSET_BITS < OFFSET_W) ? OFFSET_BITS : OFFSET_W;
	localparam logic [OFFSET_W-1:0] KEEP_MASK = {OFFSET_W{1'b1}} >> (OFFSET_W - KEEP_BITS);

	logic [NUM_BANKS-1:0][BANK_W-1:0] eff;
	logic [BANK_W-1:0]                prg_bank;
	logic [BANK_W-1:0]                chr_bank;
	logic [2:0]                       slot;
	logic [1:0]                       pair;
	logic [OFFSET_W-1:0]              raw_off;

	// Effective bank register values
	always_comb begin
		for (int i = 0; i < NUM_BANKS; i++) begin
			eff[i] = eff_reg(state.variant, SEL_W'(i), state.banks[i]);
		end
	end

	// Program window bank
	always_comb begin
		case (address[14:13])
			2'd0:    prg_bank = eff[6];
			2'd1:    prg_bank = eff[7];
			2'd2:    prg_bank = PRG_BANK_2ND_LAST;
			default: prg_bank = PRG_BANK_LAST;
		endcase
	end

	// Character page bank
	assign slot = address[12:10];
	assign pair = address[12:11];
	always_comb begin
		if (state.variant == VAR_CHR2K) begin
			chr_bank = eff[{1'b0, pair} + 3'd2];
		end else if (!slot[2]) begin
			chr_bank = {eff[{2'b00, slot[1]}][BANK_W-1:1], slot[0]};
		end else begin
			chr_bank = eff[slot - 3'd2];
		end
	end

	// Assemble the byte offset
	always_comb begin
		case (op)
			OP_PRG: raw_off = {prg_bank & state.prg_mask, address[12:0]};
			OP_CHR: begin
				if (state.variant == VAR_CHR2K) begin
					raw_off = OFFSET_W'({chr_bank & state.chr_mask, address[10:0]});
				end else begin
					raw_off = OFFSET_W'({chr_bank & state.chr_mask, address[9:0]});
				end
			end
			default: raw_off = '0;
		endcase
	end

	assign offset = raw_off & KEEP_MASK;

endmodule
